// ===== hw/rtl/dpu_pkg.sv =====
// shared types and constants for the dilution posterior update block
// no dependencies; used by the top level and its checker
package dpu_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_PRIOR = 2'd0,
    OP_LOAD_DIL   = 2'd1,
    OP_UPDATE     = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned RESP_W  = 2;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // saturated stand-in for 1.0 in q0.32
  localparam logic [VAL_W-1:0] Q_ONE_SAT = '1;

endpackage

// ===== hw/rtl/dpu_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module dpu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/dilution_posterior_update_top.sv =====
// loads, reads and empty-pool updates need no table walk; an update walks all STATES states
// in a likelihood pass that sums the weighted posteriors, then, unless the sum is zero,
// in a normalize pass that divides each by the sum (2 quotient bits a cycle)
// one item in work at a time; the next item is taken while a result waits at the output
// rst_n is synchronous, active low; it clears control and the likelihood sum,
// table contents are undefined until loaded
// depends on dpu_pkg and dpu_ram
module dilution_posterior_update_top #(
  parameter int unsigned ATOM_COUNT    = 4,
  parameter int unsigned VARIANT_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // index[7:0], value[39:8], experiment[43:40], response[45:44]
  input  logic [1:0]  in_tuser,  // operation[1:0]
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // read_value[31:0], status[33:32]
);

  localparam int unsigned SW        = ATOM_COUNT * VARIANT_COUNT;   // state index bits
  localparam int unsigned STATES    = 1 << SW;
  localparam int unsigned DIL_DEPTH = ATOM_COUNT * (ATOM_COUNT + 1);
  localparam int unsigned DIL_AW    = (DIL_DEPTH > 1) ? $clog2(DIL_DEPTH) : 1;
  localparam int unsigned VW        = (VARIANT_COUNT > 1) ? $clog2(VARIANT_COUNT) : 1;
  localparam int unsigned DIV_STEP  = 2;                            // quotient bits per cycle
  localparam int unsigned DIV_ITERS = dpu_pkg::VAL_W / DIV_STEP;
  localparam int unsigned CW        = $clog2(DIV_ITERS);

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_P_ADDR, S_P_FACT, S_P_MUL, S_P_POST, S_P_ACC,
    S_CHK, S_D_RD, S_D_START, S_D_ITER, S_D_WR, S_DONE
  } state_t;

  state_t state_r;

  // unpacked input beat
  dpu_pkg::op_t                    in_op;
  logic [dpu_pkg::IDX_W-1:0]       in_index;
  logic [dpu_pkg::VAL_W-1:0]       in_value;
  logic [dpu_pkg::EXP_W-1:0]       in_exp;
  logic [dpu_pkg::RESP_W-1:0]      in_resp;
  logic                            in_acc;
  logic                            post_ok;
  logic                            dil_ok;

  assign in_op    = dpu_pkg::op_t'(in_tuser);
  assign in_index = in_tdata[7:0];
  assign in_value = in_tdata[39:8];
  assign in_exp   = in_tdata[43:40];
  assign in_resp  = in_tdata[45:44];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign post_ok   = ((in_index >> SW) == '0);
  assign dil_ok    = (32'(in_index) < DIL_DEPTH);

  // update context
  logic [dpu_pkg::EXP_W-1:0]  pool_r;
  logic [2:0]                 psize_r;
  logic [VARIANT_COUNT-1:0]   resp_r;
  logic [SW-1:0]              s_r;
  logic [VW-1:0]              v_r;
  logic [dpu_pkg::VAL_W-1:0]  f_r, acc_r, m_r, q_r;
  logic [dpu_pkg::SUM_W-1:0]  sum_r, rem_r;
  logic [CW-1:0]              cnt_r;

  // pending result and output register
  logic [dpu_pkg::VAL_W-1:0]  res_val_r;
  dpu_pkg::status_t           res_stat_r;
  logic                       out_valid_r;
  logic [dpu_pkg::VAL_W-1:0]  out_val_r;
  dpu_pkg::status_t           out_stat_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_val_r};

  // masked pool and its size at accept
  logic [dpu_pkg::EXP_W-1:0] pool_in;
  logic [2:0]                psize_in;
  always_comb begin
    pool_in  = '0;
    psize_in = '0;
    for (int l = 0; l < dpu_pkg::EXP_W; l++) begin
      if (l < ATOM_COUNT) begin
        pool_in[l] = in_exp[l];
      end
      psize_in = psize_in + 3'(pool_in[l]);
    end
  end

  // dilution table address for state s_r, variant v_sel
  logic [VW-1:0]     v_sel;
  logic [2:0]        pos_cnt;
  logic [2:0]        neg_cnt;
  logic [DIL_AW-1:0] dil_rd_addr;
  always_comb begin
    v_sel   = (state_r == S_P_MUL) ? VW'(v_r + 1'b1) : '0;
    pos_cnt = '0;
    for (int l = 0; l < dpu_pkg::EXP_W; l++) begin
      if (l < ATOM_COUNT) begin
        if (pool_r[l] && s_r[l * VARIANT_COUNT + int'(v_sel)]) begin
          pos_cnt = pos_cnt + 3'd1;
        end
      end
    end
    neg_cnt     = psize_r - pos_cnt;
    dil_rd_addr = DIL_AW'((int'(psize_r) - 1) * (ATOM_COUNT + 1) + int'(neg_cnt));
  end

  // memories
  logic                       post_we, post_re, dil_we, dil_re, scr_we, scr_re;
  logic [SW-1:0]              post_waddr, post_raddr;
  logic [dpu_pkg::VAL_W-1:0]  post_wdata, post_rdata, dil_rdata, scr_rdata;

  assign post_we    = (in_acc && in_op == dpu_pkg::OP_LOAD_PRIOR && post_ok)
                      || (state_r == S_D_WR);
  assign post_waddr = (state_r == S_D_WR) ? s_r : SW'(in_index);
  assign post_wdata = (state_r == S_D_WR) ? q_r : in_value;
  assign post_re    = (in_acc && in_op == dpu_pkg::OP_READ && post_ok)
                      || (state_r == S_P_ADDR);
  assign post_raddr = (state_r == S_P_ADDR) ? s_r : SW'(in_index);

  assign dil_we = in_acc && in_op == dpu_pkg::OP_LOAD_DIL && dil_ok;
  assign dil_re = (state_r == S_P_ADDR)
                  || (state_r == S_P_MUL && 32'(v_r) != VARIANT_COUNT - 1);

  assign scr_we = (state_r == S_P_ACC);
  assign scr_re = (state_r == S_D_RD);

  dpu_ram #(.WIDTH(dpu_pkg::VAL_W), .DEPTH(STATES)) u_post_ram (
    .clk(clk), .wr_en(post_we), .wr_addr(post_waddr), .wr_data(post_wdata),
    .rd_en(post_re), .rd_addr(post_raddr), .rd_data(post_rdata)
  );

  dpu_ram #(.WIDTH(dpu_pkg::VAL_W), .DEPTH(DIL_DEPTH)) u_dil_ram (
    .clk(clk), .wr_en(dil_we), .wr_addr(DIL_AW'(in_index)), .wr_data(in_value),
    .rd_en(dil_re), .rd_addr(dil_rd_addr), .rd_data(dil_rdata)
  );

  // multiplied posteriors between the two passes
  dpu_ram #(.WIDTH(dpu_pkg::VAL_W), .DEPTH(STATES)) u_scr_ram (
    .clk(clk), .wr_en(scr_we), .wr_addr(s_r), .wr_data(m_r),
    .rd_en(scr_re), .rd_addr(s_r), .rd_data(scr_rdata)
  );

  // per-variant factor: detection probability or its complement
  logic [dpu_pkg::VAL_W-1:0] fact;
  always_comb begin
    if (resp_r[v_r]) begin
      fact = dil_rdata;
    end else if (dil_rdata == '0) begin
      fact = dpu_pkg::Q_ONE_SAT;
    end else begin
      fact = -dil_rdata;
    end
  end

  logic [2*dpu_pkg::VAL_W-1:0] lk_prod, post_prod;
  assign lk_prod   = acc_r * f_r;
  assign post_prod = post_rdata * acc_r;

  // restoring division, DIV_STEP quotient bits a cycle
  logic [dpu_pkg::SUM_W-1:0] rem_nxt;
  logic [dpu_pkg::VAL_W-1:0] q_nxt;
  logic [dpu_pkg::SUM_W:0]   shl;
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    shl     = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      shl = {rem_nxt, 1'b0};
      if (shl >= {1'b0, sum_r}) begin
        shl   = shl - {1'b0, sum_r};
        q_nxt = {q_nxt[dpu_pkg::VAL_W-2:0], 1'b1};
      end else begin
        q_nxt = {q_nxt[dpu_pkg::VAL_W-2:0], 1'b0};
      end
      rem_nxt = shl[dpu_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      // the done state loads the output register itself
      if (out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_val_r  <= '0;
            res_stat_r <= dpu_pkg::STAT_OK;
            pool_r     <= pool_in;
            psize_r    <= psize_in;
            resp_r     <= VARIANT_COUNT'(in_resp);
            s_r        <= '0;
            v_r        <= '0;
            unique case (in_op)
              dpu_pkg::OP_LOAD_PRIOR: begin
                if (!post_ok) res_stat_r <= dpu_pkg::STAT_RANGE;
                state_r <= S_DONE;
              end
              dpu_pkg::OP_LOAD_DIL: begin
                if (!dil_ok) res_stat_r <= dpu_pkg::STAT_RANGE;
                state_r <= S_DONE;
              end
              dpu_pkg::OP_READ: begin
                if (post_ok) begin
                  state_r <= S_RDWAIT;
                end else begin
                  res_stat_r <= dpu_pkg::STAT_RANGE;
                  state_r    <= S_DONE;
                end
              end
              dpu_pkg::OP_UPDATE: begin
                if (psize_in == '0) begin
                  res_stat_r <= dpu_pkg::STAT_EMPTY;
                  state_r    <= S_DONE;
                end else begin
                  sum_r   <= '0;
                  state_r <= S_P_ADDR;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RDWAIT: begin
          res_val_r <= post_rdata;
          state_r   <= S_DONE;
        end
        // likelihood pass
        S_P_ADDR: begin
          v_r     <= '0;
          state_r <= S_P_FACT;
        end
        S_P_FACT: begin
          f_r     <= fact;
          state_r <= S_P_MUL;
        end
        S_P_MUL: begin
          if (v_r == '0) begin
            acc_r <= f_r;
          end else begin
            acc_r <= lk_prod[2*dpu_pkg::VAL_W-1:dpu_pkg::VAL_W];
          end
          if (32'(v_r) == VARIANT_COUNT - 1) begin
            state_r <= S_P_POST;
          end else begin
            v_r     <= VW'(v_r + 1'b1);
            state_r <= S_P_FACT;
          end
        end
        S_P_POST: begin
          m_r     <= post_prod[2*dpu_pkg::VAL_W-1:dpu_pkg::VAL_W];
          state_r <= S_P_ACC;
        end
        S_P_ACC: begin
          sum_r <= sum_r + dpu_pkg::SUM_W'(m_r);
          if (&s_r) begin
            state_r <= S_CHK;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_P_ADDR;
          end
        end
        S_CHK: begin
          s_r <= '0;
          if (sum_r == '0) begin
            res_stat_r <= dpu_pkg::STAT_ZERO;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_D_RD;
          end
        end
        // normalize pass
        S_D_RD: begin
          state_r <= S_D_START;
        end
        S_D_START: begin
          if (dpu_pkg::SUM_W'(scr_rdata) >= sum_r) begin
            // quotient would reach 1.0
            q_r     <= dpu_pkg::Q_ONE_SAT;
            state_r <= S_D_WR;
          end else begin
            rem_r   <= dpu_pkg::SUM_W'(scr_rdata);
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_D_ITER;
          end
        end
        S_D_ITER: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == DIV_ITERS - 1) begin
            state_r <= S_D_WR;
          end
        end
        S_D_WR: begin
          if (&s_r) begin
            state_r <= S_DONE;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_D_RD;
          end
        end
        S_DONE: begin
          // hand the result to the output register once it is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_stat_r  <= res_stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dpu_checker.sv =====
// port-level checker for the dilution posterior update top level
// depends on dpu_pkg; bound to dilution_posterior_update_top below
module dpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in work");

  // a read value only comes with ok status
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:0] == '0 || out_tdata[33:32] == dpu_pkg::STAT_OK))
    else $error("nonzero read value with error status");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dilution_posterior_update_top dpu_checker u_dpu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/dilution_posterior_update_checker.sv =====
// checker for the dilution posterior update block: watches both streams,
// predicts every result beat and compares it; depends on dpu_pkg
module dilution_posterior_update_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int ATOMS  = 4;
  localparam int VARS   = 2;
  localparam int STATES = 1 << (ATOMS * VARS);
  localparam int DIL_N  = ATOMS * (ATOMS + 1);

  typedef struct packed {
    logic [31:0]      read_value;
    dpu_pkg::status_t status;
  } result_t;

  logic [31:0]  posterior_q [STATES];
  logic [31:0]  detect_prob [DIL_N];
  logic [39:0]  weight_sum;
  result_t      expected_results [$];

  function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[63:32];
  endfunction

  // product of the per-variant detection factors for one joint state
  function automatic logic [31:0] state_likelihood(logic [3:0] pool, logic [1:0] resp,
                                                   int st);
    int psize, neg, idx;
    logic [3:0]  carried;
    logic [31:0] acc, p, f;
    psize = $countones(pool);
    acc = '0;
    for (int v = 0; v < VARS; v++) begin
      carried = '0;
      for (int l = 0; l < ATOMS; l++) carried[l] = st[l*VARS+v];
      neg = psize - $countones(pool & carried);
      idx = (psize - 1) * (ATOMS + 1) + neg;
      p = (idx < DIL_N) ? detect_prob[idx] : 32'd0;
      if (resp[v]) f = p;
      else f = (p == 0) ? dpu_pkg::Q_ONE_SAT : 32'(33'h1_0000_0000 - {1'b0, p});
      acc = (v == 0) ? f : qmul(acc, f);
    end
    return acc;
  endfunction

  function automatic result_t predict_beat(dpu_pkg::op_t op, logic [7:0] idx,
                                           logic [31:0] val, logic [3:0] pool,
                                           logic [1:0] resp);
    result_t r;
    logic [31:0] scaled [STATES];
    logic [63:0] total, q;
    r.read_value = '0;
    r.status = dpu_pkg::STAT_OK;
    case (op)
      dpu_pkg::OP_LOAD_PRIOR: posterior_q[idx] = val;
      dpu_pkg::OP_LOAD_DIL: begin
        if (idx < DIL_N) detect_prob[idx] = val;
        else r.status = dpu_pkg::STAT_RANGE;
      end
      dpu_pkg::OP_READ: r.read_value = posterior_q[idx];
      default: begin
        if (pool == 0) begin
          r.status = dpu_pkg::STAT_EMPTY;
        end else begin
          total = '0;
          for (int s = 0; s < STATES; s++) begin
            scaled[s] = qmul(posterior_q[s], state_likelihood(pool, resp, s));
            total += scaled[s];
          end
          weight_sum = total[39:0];
          if (weight_sum == 0) begin
            r.status = dpu_pkg::STAT_ZERO;
          end else begin
            for (int s = 0; s < STATES; s++) begin
              q = {scaled[s], 32'd0} / {24'd0, weight_sum};
              posterior_q[s] = (q > 64'hFFFF_FFFF) ? dpu_pkg::Q_ONE_SAT : q[31:0];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t want, got;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      weight_sum = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_beat(dpu_pkg::op_t'(in_tuser), in_tdata[7:0],
                                   in_tdata[39:8], in_tdata[43:40], in_tdata[45:44]));
      if (out_tvalid && out_tready) begin
        got.read_value = out_tdata[31:0];
        got.status = dpu_pkg::status_t'(out_tdata[33:32]);
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %h status %0d",
                   $time, got.read_value, got.status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (want.read_value !== got.read_value) begin
            $display("%0t: read_value mismatch: expected %h actual %h",
                     $time, want.read_value, got.read_value);
            errs++;
          end
          if (want.status !== got.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== tb/dilution_posterior_update_top_tb.sv =====
// testbench top for dilution_posterior_update_top: drives input beats,
// throttles the result stream and gives the verdict; depends on dpu_pkg and the checker
module dilution_posterior_update_top_tb;

  localparam int RANDOM_ITEMS = 710;
  localparam int CALM_TAIL    = 120;     // last items run with no idling
  localparam int STALL_LIMIT  = 30000;   // cycles with no beat on either side

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;  // index[7:0], value[39:8], experiment[43:40], response[45:44]
  logic [1:0]  in_tuser;  // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata; // read_value[31:0], status[33:32]

  int  fail_count;
  int  pending;
  bit  calm;
  int  beats_sent;
  int  updates_sent;
  int  idle_cnt;

  dilution_posterior_update_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  dilution_posterior_update_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // drive one input beat and hold it until the block takes it
  task automatic send_beat(dpu_pkg::op_t op, logic [7:0] idx, logic [31:0] val,
                           logic [3:0] pool, logic [1:0] resp);
    // random idle burst ahead of the beat, none in the calm tail
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, resp, pool, val, idx};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (op == dpu_pkg::OP_UPDATE) updates_sent++;
  endtask

  // random probability, extremes now and then
  function automatic logic [31:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return dpu_pkg::Q_ONE_SAT;
      default: return $urandom;
    endcase
  endfunction

  // receiver: ready toggles in random bursts, always ready in the calm tail
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= $urandom_range(0, 2) != 0;
        repeat ($urandom_range(0, 18)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = dpu_pkg::OP_LOAD_PRIOR;
    calm         = 1'b0;
    beats_sent   = 0;
    updates_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables so that no later beat touches an unwritten entry
    for (int i = 0; i < 256; i++)
      send_beat(dpu_pkg::OP_LOAD_PRIOR, 8'(i),
                (i == 0) ? 32'd0 : (i == 255) ? dpu_pkg::Q_ONE_SAT : $urandom,
                4'($urandom), 2'($urandom));
    for (int i = 0; i < 20; i++)
      send_beat(dpu_pkg::OP_LOAD_DIL, 8'(i),
                (i == 0) ? 32'd0 : (i == 19) ? dpu_pkg::Q_ONE_SAT : $urandom,
                4'($urandom), 2'($urandom));

    // directed: range errors, extreme reads, empty pool, full pool, zero total
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd20, $urandom, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd255, dpu_pkg::Q_ONE_SAT, 4'hF, 2'b11);
    send_beat(dpu_pkg::OP_READ, 8'd0, dpu_pkg::Q_ONE_SAT, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_READ, 8'd255, 32'd0, 4'hF, 2'b11);
    send_beat(dpu_pkg::OP_UPDATE, 8'd0, $urandom, 4'h0, 2'b11);   // empty pool
    send_beat(dpu_pkg::OP_UPDATE, 8'd0, $urandom, 4'hF, 2'b00);
    send_beat(dpu_pkg::OP_UPDATE, 8'd7, $urandom, 4'h1, 2'b11);
    send_beat(dpu_pkg::OP_UPDATE, 8'd9, $urandom, 4'h6, 2'b10);
    send_beat(dpu_pkg::OP_READ, 8'd5, 32'd0, 4'h0, 2'b00);
    // zero detection for single-atom pools makes a positive test impossible
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd0, 32'd0, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd1, 32'd0, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_UPDATE, 8'd0, 32'd0, 4'h2, 2'b01);      // zero total
    send_beat(dpu_pkg::OP_READ, 8'd17, 32'd0, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd1, $urandom, 4'h0, 2'b00);
    send_beat(dpu_pkg::OP_LOAD_DIL, 8'd0, $urandom, 4'h0, 2'b00);

    // random mix; updates kept rare since each walks the whole table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_TAIL);
      sel = $urandom_range(0, 99);
      if (sel < 35)
        send_beat(dpu_pkg::OP_LOAD_PRIOR, 8'($urandom), rand_prob(), 4'($urandom),
                  2'($urandom));
      else if (sel < 50)
        send_beat(dpu_pkg::OP_LOAD_DIL, 8'($urandom_range(0, 23)), rand_prob(),
                  4'($urandom), 2'($urandom));
      else if (sel < 92)
        send_beat(dpu_pkg::OP_READ, 8'($urandom), $urandom, 4'($urandom), 2'($urandom));
      else
        send_beat(dpu_pkg::OP_UPDATE, 8'($urandom), $urandom,
                  ($urandom_range(0, 15) == 0) ? 4'h0 : 4'($urandom), 2'($urandom));
    end
    in_tvalid <= 1'b0;
    calm = 1'b1;

    // drain, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d input beats, %0d of them posterior updates,", beats_sent,
             updates_sent);
    $display("with table loads, range errors, empty pools and a zero total");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
